FILE: rtl/core/dssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSSS despreader package
// Shared widths, register indexes and types of the despreader core.
// ----------------------------------------------------------------------------
package dssd_pkg;

  localparam int unsigned MAX_CODE_LENGTH_DEF  = 64;
  localparam int unsigned SKIP_COUNT_WIDTH_DEF = 16;

  // register and field widths fixed by the programming model
  localparam int unsigned CODE_W     = 64;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned ERR_W      = 6;
  localparam int unsigned SKIP_OUT_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS  = 2'd2;

  localparam logic [CODE_W-1:0] SPREAD_CODE_RST = 64'd1810;
  localparam logic [CNT_W-1:0]  CODE_LENGTH_RST = 7'd11;
  localparam logic [CNT_W-1:0]  MAX_ERRORS_RST  = 7'd2;

  // decision settings, length already clamped to the legal range
  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] max_err;
  } dec_cfg_t;

endpackage

FILE: rtl/core/dssd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSSS despreader channel interfaces
// Valid/ready channels for chips, despread results and register writes.
// ----------------------------------------------------------------------------
interface dssd_chip_if ();
  logic valid;
  logic ready;
  logic chip;

  modport source (output valid, output chip, input ready);
  modport sink (input valid, input chip, output ready);
endinterface

interface dssd_result_if import dssd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  data_bit;
  logic [ERR_W-1:0]      chip_errors;
  logic [SKIP_OUT_W-1:0] skipped_chips;

  modport source (output valid, output data_bit, output chip_errors,
                  output skipped_chips, input ready);
  modport sink (input valid, input data_bit, input chip_errors,
                input skipped_chips, output ready);
endinterface

interface dssd_cfg_if import dssd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CODE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/dssd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Despreader chip cell
// Holds one chip of the window, passes it on at each request and registers
// its mismatch against the matching code chip.
// ----------------------------------------------------------------------------
module dssd_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic adv_i,
  input  logic chip_i,
  input  logic code_bit_i,
  input  logic in_use_i,
  output logic chip_o,
  output logic mism_o
);

  logic chip_q, chip_d;
  logic mism_q, mism_d;

  assign chip_d = shift_i ? chip_i : chip_q;
  assign mism_d = adv_i ? ((chip_q ^ code_bit_i) & in_use_i) : mism_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_q <= 1'b0;
    end else begin
      chip_q <= chip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mism_q <= mism_d;
  end

  assign chip_o = chip_q;
  assign mism_o = mism_q;

endmodule

FILE: rtl/core/dssd_popcount.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Despreader mismatch counter
// Two-stage registered popcount: byte sums, then the sum of the bytes.
// ----------------------------------------------------------------------------
module dssd_popcount import dssd_pkg::*; #(
  parameter int unsigned N = MAX_CODE_LENGTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [N-1:0]     mism_i,
  output logic             valid_o,
  output logic [CNT_W-1:0] count_o
);

  localparam int unsigned NGRP = (N + 7) / 8;

  logic [NGRP*8-1:0]  mism_pad;
  logic [3:0]         grp_q [NGRP];
  logic [3:0]         grp_d [NGRP];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               v2_q, v3_q;

  assign mism_pad = (NGRP*8)'(mism_i);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        grp_d[g] = grp_d[g] + 4'(mism_pad[g*8+b]);
      end
    end
  end

  always_comb begin
    cnt_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      cnt_d = cnt_d + CNT_W'(grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      grp_q <= grp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign count_o = cnt_q;

endmodule

FILE: rtl/core/dssd_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Despreader bit decision
// Tracks fresh chips and slides, takes the bit decision and holds the
// result register. Also drives the pipeline advance.
// ----------------------------------------------------------------------------
module dssd_decide import dssd_pkg::*; #(
  parameter int unsigned MAX_CODE_LENGTH  = MAX_CODE_LENGTH_DEF,
  parameter int unsigned SKIP_COUNT_WIDTH = SKIP_COUNT_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dec_cfg_t         cfg_i,
  input  logic             valid_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             adv_o,
  dssd_result_if.source    result_o
);

  localparam int unsigned WIDE_W = (SKIP_COUNT_WIDTH > SKIP_OUT_W) ?
                                   SKIP_COUNT_WIDTH : SKIP_OUT_W;

  logic [CNT_W-1:0]            fresh_q, fresh_d, fresh_inc;
  logic [SKIP_COUNT_WIDTH-1:0] skip_q, skip_d;
  logic                        out_valid_q, out_valid_d;
  logic                        bit_q, bit_d;
  logic [ERR_W-1:0]            err_q, err_d;
  logic [SKIP_OUT_W-1:0]       skip_out_q, skip_out_d;
  logic [WIDE_W-1:0]           skip_wide;
  logic                        full, bit_c, ok, emit, fire;
  logic [CNT_W-1:0]            err_c;

  assign fresh_inc = (fresh_q < CNT_W'(MAX_CODE_LENGTH)) ? fresh_q + 1'b1 : fresh_q;
  assign full      = fresh_inc >= cfg_i.len;
  assign bit_c     = count_i > (cfg_i.len >> 1);
  assign err_c     = bit_c ? cfg_i.len - count_i : count_i;
  assign ok        = !(err_c > cfg_i.max_err);
  assign emit      = full & ok;

  // stall only when this item would emit into a result still waiting
  assign adv_o = !(out_valid_q & !result_o.ready & valid_i & emit);
  assign fire  = adv_o & valid_i;

  assign skip_wide  = WIDE_W'(skip_q);
  assign skip_out_d = (skip_wide > WIDE_W'({SKIP_OUT_W{1'b1}})) ?
                      {SKIP_OUT_W{1'b1}} : skip_wide[SKIP_OUT_W-1:0];

  always_comb begin
    fresh_d     = fresh_q;
    skip_d      = skip_q;
    out_valid_d = out_valid_q & !result_o.ready;
    bit_d       = bit_q;
    err_d       = err_q;
    if (fire) begin
      if (!full) begin
        fresh_d = fresh_inc;
      end else if (!ok) begin
        fresh_d = fresh_inc;
        if (skip_q != {SKIP_COUNT_WIDTH{1'b1}}) begin
          skip_d = skip_q + 1'b1;
        end
      end else begin
        fresh_d     = '0;
        skip_d      = '0;
        out_valid_d = 1'b1;
        bit_d       = bit_c;
        err_d       = err_c[ERR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fresh_q     <= fresh_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire & emit) begin
      skip_out_q <= skip_out_d;
    end
    bit_q <= bit_d;
    err_q <= err_d;
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.data_bit      = bit_q;
  assign result_o.chip_errors   = err_q;
  assign result_o.skipped_chips = skip_out_q;

endmodule

FILE: rtl/core/dsss_chip_despreader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSSS chip despreader core
// Hard-decision correlator: chip window, mismatch count, bit decision.
// ----------------------------------------------------------------------------
// One chip is taken per clock. Chips shift through a row of cells, one per
// code position, each registering its mismatch against the spreading code;
// a two-stage popcount and the registered bit decision follow. The row of
// cells and the popcount are fully pipelined; the only stall is when a bit
// is ready while the previous result has not yet been taken. The user must
// write registers through the config channel only while no chips are in
// flight; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module dsss_chip_despreader_core import dssd_pkg::*; #(
  parameter int unsigned MAX_CODE_LENGTH  = MAX_CODE_LENGTH_DEF,
  parameter int unsigned SKIP_COUNT_WIDTH = SKIP_COUNT_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dssd_chip_if.sink     chip_i,
  dssd_cfg_if.sink      cfg_i,
  dssd_result_if.source result_o
);

  logic [CODE_W-1:0]          code_q, code_d;
  logic [CNT_W-1:0]           len_q, len_d;
  logic [CNT_W-1:0]           maxerr_q, maxerr_d;
  logic [CNT_W-1:0]           len_eff;
  dec_cfg_t                   dec_cfg;
  logic                       adv, accept;
  logic                       v0_q, v0_d, v1_q, v1_d;
  logic [MAX_CODE_LENGTH-1:0] window, mism, in_use;
  logic                       cnt_valid;
  logic [CNT_W-1:0]           cnt;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_comb begin
    code_d   = code_q;
    len_d    = len_q;
    maxerr_d = maxerr_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SPREAD_CODE: code_d   = cfg_i.data;
        REG_CODE_LENGTH: len_d    = cfg_i.data[CNT_W-1:0];
        REG_MAX_ERRORS:  maxerr_d = cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q   <= SPREAD_CODE_RST;
      len_q    <= CODE_LENGTH_RST;
      maxerr_q <= MAX_ERRORS_RST;
    end else begin
      code_q   <= code_d;
      len_q    <= len_d;
      maxerr_q <= maxerr_d;
    end
  end

  always_comb begin
    if (len_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (len_q > CNT_W'(MAX_CODE_LENGTH)) begin
      len_eff = CNT_W'(MAX_CODE_LENGTH);
    end else begin
      len_eff = len_q;
    end
  end

  assign dec_cfg.len     = len_eff;
  assign dec_cfg.max_err = maxerr_q;

  always_comb begin
    for (int k = 0; k < MAX_CODE_LENGTH; k++) begin
      in_use[k] = CNT_W'(k) < len_eff;
    end
  end

  // pipeline control: v0 tracks the window, v1 the mismatch row
  assign chip_i.ready = adv;
  assign accept       = chip_i.valid & adv;
  assign v0_d         = accept | (v0_q & !adv);
  assign v1_d         = adv ? v0_q : v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  // bit 0 holds the newest chip, the oldest ends up at len - 1
  for (genvar k = 0; k < MAX_CODE_LENGTH; k++) begin : g_cell
    logic chip_in;
    if (k == 0) begin : g_head
      assign chip_in = chip_i.chip;
    end else begin : g_link
      assign chip_in = window[k-1];
    end
    dssd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (accept),
      .adv_i      (adv),
      .chip_i     (chip_in),
      .code_bit_i (code_q[k]),
      .in_use_i   (in_use[k]),
      .chip_o     (window[k]),
      .mism_o     (mism[k])
    );
  end

  dssd_popcount #(
    .N (MAX_CODE_LENGTH)
  ) u_popcount (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v1_q),
    .mism_i  (mism),
    .valid_o (cnt_valid),
    .count_o (cnt)
  );

  dssd_decide #(
    .MAX_CODE_LENGTH  (MAX_CODE_LENGTH),
    .SKIP_COUNT_WIDTH (SKIP_COUNT_WIDTH)
  ) u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (dec_cfg),
    .valid_i  (cnt_valid),
    .count_i  (cnt),
    .adv_o    (adv),
    .result_o (result_o)
  );

endmodule
